// ----- rtl/core/lrs_pkg.sv -----
// Shared types and constants of the LRU replacement set core.
`default_nettype none

package lrs_pkg;

  localparam int RANK_W    = 4;
  localparam int WAY_W     = 4;
  localparam int SET_IDX_W = 10;
  localparam int MASK_W    = 16;

  localparam int WAYS_DEF = 16;
  localparam int SETS_DEF = 1024;

  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                 cmd;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way_index;
    logic [MASK_W-1:0]    valid_mask;
    logic                 is_writeback;
    logic                 was_hit;
  } req_t;

  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             none;
  } victim_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrs_if.sv -----
// Channel interfaces for requests and victim results.
`default_nettype none

interface lrs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [lrs_pkg::SET_IDX_W-1:0] set_index;
  logic [lrs_pkg::WAY_W-1:0]     way_index;
  logic [lrs_pkg::MASK_W-1:0]    valid_mask;
  logic                          is_writeback;
  logic                          was_hit;

  modport source (output valid, cmd, set_index, way_index, valid_mask, is_writeback,
                  was_hit, input ready);
  modport sink (input valid, cmd, set_index, way_index, valid_mask, is_writeback,
                was_hit, output ready);
endinterface

interface lrs_out_if;
  logic                      valid;
  logic                      ready;
  logic [lrs_pkg::WAY_W-1:0] victim_way;
  logic                      no_victim;

  modport source (output valid, victim_way, no_victim, input ready);
  modport sink (input valid, victim_way, no_victim, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lrs_rank_logic.sv -----
// Victim selection and rank aging for one set's rank word.
`default_nettype none

module lrs_rank_logic #(
  parameter int WAYS = lrs_pkg::WAYS_DEF
) (
  input  wire logic [lrs_pkg::RANK_W*WAYS-1:0] rank_word,
  input  wire logic [lrs_pkg::WAY_W-1:0]       way_index,
  input  wire logic [lrs_pkg::MASK_W-1:0]      valid_mask,
  output lrs_pkg::victim_t                     victim,
  output logic                                 upd_ok,
  output logic [lrs_pkg::RANK_W*WAYS-1:0]      upd_word
);

  localparam int RW = lrs_pkg::RANK_W;

  logic [lrs_pkg::WAY_W-1:0] way_sel;
  logic [RW-1:0]             acc_rank;

  assign upd_ok  = ({1'b0, way_index} < (lrs_pkg::WAY_W + 1)'(WAYS));
  assign way_sel = upd_ok ? way_index : '0;
  assign acc_rank = rank_word[way_sel*RW +: RW];

  // Lowest invalid way first; otherwise the way holding the oldest rank.
  always_comb begin
    logic                      has_inv;
    logic                      has_old;
    logic [lrs_pkg::WAY_W-1:0] inv_way;
    logic [lrs_pkg::WAY_W-1:0] old_way;
    has_inv = 1'b0;
    has_old = 1'b0;
    inv_way = '0;
    old_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_mask[w]) begin
        has_inv = 1'b1;
        inv_way = lrs_pkg::WAY_W'(w);
      end
      if (rank_word[w*RW +: RW] == RW'(WAYS - 1)) begin
        has_old = 1'b1;
        old_way = lrs_pkg::WAY_W'(w);
      end
    end
    priority if (has_inv) begin
      victim.way = inv_way;
    end else if (has_old) begin
      victim.way = old_way;
    end else begin
      victim.way = '0;
    end
    victim.none = !has_inv && !has_old;
  end

  always_comb begin
    logic [RW-1:0] rw;
    upd_word = rank_word;
    for (int w = 0; w < WAYS; w++) begin
      rw = rank_word[w*RW +: RW];
      if (lrs_pkg::WAY_W'(w) == way_sel) begin
        upd_word[w*RW +: RW] = '0;
      end else if (rw < acc_rank) begin
        upd_word[w*RW +: RW] = rw + RW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lru_replacement_set_core.sv -----
// After an input transfer, DIV and MOD reduce the set index, READ reads the rank word and
// EXEC writes back an update or loads the victim result into the output register; EXEC
// waits while that register is full and not taken. One request is in work at a time.
// Reset: synchronous, active low; a clearing pass then writes every set's rank word to
// rank w for way w, and no input is taken until it completes.
`default_nettype none

module lru_replacement_set_core #(
  parameter int WAYS = lrs_pkg::WAYS_DEF,
  parameter int SETS = lrs_pkg::SETS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lrs_in_if.sink    in_ch,
  lrs_out_if.source out_ch
);

  localparam int RW     = lrs_pkg::RANK_W;
  localparam int WORD_W = RW * WAYS;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int IDX_W  = lrs_pkg::SET_IDX_W;
  localparam int RECIP  = (1 << IDX_W) / SETS;
  localparam int PROD_W = 2 * IDX_W + 1;
  localparam int CALC_W = 24;

  lrs_pkg::state_t state_r, state_nxt;
  lrs_pkg::req_t   req_r;

  logic [SET_W-1:0]  clr_cnt_r;
  logic [IDX_W-1:0]  quot_r;
  logic [SET_W-1:0]  set_r;
  logic [WORD_W-1:0] rank_mem [SETS];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] init_word;

  logic              rd_en;
  logic              wr_en;
  logic [SET_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              out_load;
  logic              in_take;

  lrs_pkg::victim_t  victim;
  logic              upd_ok;
  logic [WORD_W-1:0] upd_word;

  logic                      out_valid_r;
  logic [lrs_pkg::WAY_W-1:0] victim_way_r;
  logic                      no_victim_r;

  logic [PROD_W-1:0] prod;
  logic [CALC_W-1:0] rem0;
  logic [CALC_W-1:0] rem1;

  logic is_victim;
  logic upd_skip;

  always_comb begin
    init_word = '0;
    for (int w = 0; w < WAYS; w++) begin
      init_word[w*RW +: RW] = RW'(w);
    end
  end

  // Set index modulo SETS: reciprocal estimate, then one correcting subtract.
  assign prod = PROD_W'(req_r.set_index) * PROD_W'(RECIP);
  assign rem0 = CALC_W'(req_r.set_index) - CALC_W'(quot_r) * CALC_W'(SETS);
  assign rem1 = (rem0 >= CALC_W'(SETS)) ? (rem0 - CALC_W'(SETS)) : rem0;

  assign is_victim = (req_r.cmd == lrs_pkg::CMD_VICTIM);
  assign upd_skip  = req_r.is_writeback && req_r.was_hit;
  assign in_take   = in_ch.valid && in_ch.ready;

  lrs_rank_logic #(
    .WAYS(WAYS)
  ) u_rank_logic (
    .rank_word (rd_data_r),
    .way_index (req_r.way_index),
    .valid_mask(req_r.valid_mask),
    .victim    (victim),
    .upd_ok    (upd_ok),
    .upd_word  (upd_word)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrs_pkg::ST_CLEAR: begin
        if (clr_cnt_r == SET_W'(SETS - 1)) state_nxt = lrs_pkg::ST_IDLE;
      end
      lrs_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = lrs_pkg::ST_DIV;
      end
      lrs_pkg::ST_DIV:  state_nxt = lrs_pkg::ST_MOD;
      lrs_pkg::ST_MOD:  state_nxt = lrs_pkg::ST_READ;
      lrs_pkg::ST_READ: state_nxt = lrs_pkg::ST_EXEC;
      lrs_pkg::ST_EXEC: begin
        if (!is_victim || !out_valid_r || out_ch.ready) state_nxt = lrs_pkg::ST_IDLE;
      end
      default: state_nxt = lrs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = set_r;
    wr_data     = upd_word;
    out_load    = 1'b0;
    unique case (state_r)
      lrs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = init_word;
      end
      lrs_pkg::ST_IDLE: in_ch.ready = 1'b1;
      lrs_pkg::ST_DIV:  ;
      lrs_pkg::ST_MOD:  ;
      lrs_pkg::ST_READ: rd_en = 1'b1;
      lrs_pkg::ST_EXEC: begin
        wr_en    = !is_victim && !upd_skip && upd_ok;
        out_load = is_victim && (!out_valid_r || out_ch.ready);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrs_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lrs_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + SET_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.cmd          <= in_ch.cmd;
      req_r.set_index    <= in_ch.set_index;
      req_r.way_index    <= in_ch.way_index;
      req_r.valid_mask   <= in_ch.valid_mask;
      req_r.is_writeback <= in_ch.is_writeback;
      req_r.was_hit      <= in_ch.was_hit;
    end
    if (state_r == lrs_pkg::ST_DIV) quot_r <= prod[2*IDX_W-1:IDX_W];
    if (state_r == lrs_pkg::ST_MOD) set_r <= SET_W'(rem1);
    if (out_load) begin
      victim_way_r <= victim.way;
      no_victim_r  <= victim.none;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rank_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= rank_mem[set_r];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.victim_way = victim_way_r;
  assign out_ch.no_victim  = no_victim_r;

endmodule

`default_nettype wire

// ----- rtl/core/lrs_checker.sv -----
// Port-level checks for the LRU replacement set core, bound to the top level.
`default_nettype none

module lrs_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [lrs_pkg::WAY_W-1:0] victim_way,
  input wire logic                      no_victim
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(victim_way) && $stable(no_victim))
    else $error("result payload changed while stalled");

  // The no-victim answer always reports way zero.
  a_none_way: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_victim |-> victim_way == '0)
    else $error("no-victim result carries a nonzero way");

  // One request is in work at a time, so an input transfer closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in work");

  // Reset starts the clearing pass with nothing offered on either side.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ports active right after reset");

endmodule

bind lru_replacement_set_core lrs_checker u_lrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .victim_way(out_ch.victim_way),
  .no_victim (out_ch.no_victim)
);

`default_nettype wire

// ----- verif/lrs_checker.sv -----
`timescale 1ns / 100ps
// Checker for the LRU replacement set core: keeps its own rank words and checks every victim.
module lrs_scoreboard #(
  parameter int WAYS = lrs_pkg::WAYS_DEF,
  parameter int SETS = lrs_pkg::SETS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lrs_in_if    req_ch,
  lrs_out_if   vic_ch,
  output int   mismatch_count,
  output int   victims_pending
);

  typedef logic [WAYS-1:0][lrs_pkg::RANK_W-1:0] rank_word_t;

  rank_word_t        rank_word [SETS];
  lrs_pkg::victim_t  victim_queue [$];

  initial begin
    mismatch_count  = 0;
    victims_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic rank_word_t fresh_ranks();
    rank_word_t word;
    for (int w = 0; w < WAYS; w++) word[w] = lrs_pkg::RANK_W'(w);
    return word;
  endfunction

  // The lowest invalid way wins; otherwise the lowest way holding the oldest rank.
  function automatic lrs_pkg::victim_t choose_victim(input logic [lrs_pkg::MASK_W-1:0] mask,
                                                     input rank_word_t word);
    lrs_pkg::victim_t v;
    v.way  = '0;
    v.none = 1'b1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (word[w] == lrs_pkg::RANK_W'(WAYS - 1)) begin
        v.way  = lrs_pkg::WAY_W'(w);
        v.none = 1'b0;
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!mask[w]) begin
        v.way  = lrs_pkg::WAY_W'(w);
        v.none = 1'b0;
      end
    end
    return v;
  endfunction

  function automatic rank_word_t promote_way(input rank_word_t word, input int way);
    rank_word_t                aged;
    logic [lrs_pkg::RANK_W-1:0] old_rank;
    aged     = word;
    old_rank = word[way];
    for (int w = 0; w < WAYS; w++) begin
      if (word[w] < old_rank) aged[w] = word[w] + 1'b1;
    end
    aged[way] = '0;
    return aged;
  endfunction

  always @(posedge clk) begin : watch
    lrs_pkg::req_t    req;
    lrs_pkg::victim_t want;
    int               set_idx;
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) rank_word[s] = fresh_ranks();
      victim_queue.delete();
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        req.cmd          = req_ch.cmd;
        req.set_index    = req_ch.set_index;
        req.way_index    = req_ch.way_index;
        req.valid_mask   = req_ch.valid_mask;
        req.is_writeback = req_ch.is_writeback;
        req.was_hit      = req_ch.was_hit;
        set_idx = int'(req.set_index) % SETS;
        if (req.cmd == lrs_pkg::CMD_VICTIM) begin
          victim_queue.push_back(choose_victim(req.valid_mask, rank_word[set_idx]));
        end else if (!(req.is_writeback && req.was_hit) && int'(req.way_index) < WAYS) begin
          rank_word[set_idx] = promote_way(rank_word[set_idx], int'(req.way_index));
        end
      end
      if (vic_ch.valid && vic_ch.ready) begin
        if (victim_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result way=%0d none=%0b",
                                    vic_ch.victim_way, vic_ch.no_victim));
        end else begin
          want = victim_queue.pop_front();
          if (vic_ch.victim_way !== want.way)
            report_mismatch($sformatf("victim_way got %0d, expected %0d",
                                      vic_ch.victim_way, want.way));
          if (vic_ch.no_victim !== want.none)
            report_mismatch($sformatf("no_victim got %0b, expected %0b",
                                      vic_ch.no_victim, want.none));
        end
      end
    end
    victims_pending = victim_queue.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top of the LRU replacement set core testbench: clock, reset, request stimulus and verdict.
module testbench;

  localparam int WAYS         = lrs_pkg::WAYS_DEF;
  localparam int SETS         = lrs_pkg::SETS_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOT_SETS     = 4;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b1;
  int   mismatch_count;
  int   victims_pending;
  int   hot_set [HOT_SETS];

  lrs_in_if  req_ch ();
  lrs_out_if vic_ch ();

  lru_replacement_set_core #(.WAYS(WAYS), .SETS(SETS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (vic_ch)
  );

  lrs_scoreboard #(.WAYS(WAYS), .SETS(SETS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ch          (req_ch),
    .vic_ch          (vic_ch),
    .mismatch_count  (mismatch_count),
    .victims_pending (victims_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mostly no gap, sometimes a few cycles, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lrs_pkg::req_t victim_req(input int set_idx,
                                               input logic [lrs_pkg::MASK_W-1:0] mask);
    lrs_pkg::req_t r;
    r.cmd          = lrs_pkg::CMD_VICTIM;
    r.set_index    = lrs_pkg::SET_IDX_W'(set_idx);
    r.way_index    = lrs_pkg::WAY_W'($urandom);
    r.valid_mask   = mask;
    r.is_writeback = 1'($urandom);
    r.was_hit      = 1'($urandom);
    return r;
  endfunction

  function automatic lrs_pkg::req_t update_req(input int set_idx, input int way, input bit wb,
                                               input bit hit);
    lrs_pkg::req_t r;
    r.cmd          = lrs_pkg::CMD_UPDATE;
    r.set_index    = lrs_pkg::SET_IDX_W'(set_idx);
    r.way_index    = lrs_pkg::WAY_W'(way);
    r.valid_mask   = lrs_pkg::MASK_W'($urandom);
    r.is_writeback = wb;
    r.was_hit      = hit;
    return r;
  endfunction

  // Most traffic works a few hot sets so the ranks get well shuffled before a victim lookup.
  function automatic lrs_pkg::req_t random_req();
    lrs_pkg::req_t r;
    int            pick;
    int            set_idx;
    int            mask_pick;
    pick    = $urandom_range(0, 99);
    set_idx = hot_set[$urandom_range(0, HOT_SETS - 1)];
    if (pick < 10) begin
      r.cmd          = 1'($urandom);
      r.set_index    = lrs_pkg::SET_IDX_W'($urandom);
      r.way_index    = lrs_pkg::WAY_W'($urandom);
      r.valid_mask   = lrs_pkg::MASK_W'($urandom);
      r.is_writeback = 1'($urandom);
      r.was_hit      = 1'($urandom);
    end else if (pick < 58) begin
      r = update_req(set_idx, $urandom_range(0, WAYS - 1), 1'($urandom), 1'($urandom));
    end else begin
      mask_pick = $urandom_range(0, 9);
      if (mask_pick < 7) begin
        r = victim_req(set_idx, '1);
      end else if (mask_pick < 9) begin
        r = victim_req(set_idx, ~(lrs_pkg::MASK_W'(1) << $urandom_range(0, 15)));
      end else begin
        r = victim_req(set_idx, lrs_pkg::MASK_W'($urandom));
      end
    end
    return r;
  endfunction

  // Entered and left at a falling edge; the request is held until its transfer.
  task automatic send_req(input lrs_pkg::req_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.cmd          = r.cmd;
    req_ch.set_index    = r.set_index;
    req_ch.way_index    = r.way_index;
    req_ch.valid_mask   = r.valid_mask;
    req_ch.is_writeback = r.is_writeback;
    req_ch.was_hit      = r.was_hit;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  initial begin : result_stalls
    int stall_left;
    stall_left   = 0;
    vic_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        vic_ch.ready = 1'b0;
        stall_left--;
      end else begin
        vic_ch.ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    lrs_pkg::req_t directed [$];
    lrs_pkg::req_t r;
    int            issued;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = lrs_pkg::CMD_VICTIM;
    req_ch.set_index    = '0;
    req_ch.way_index    = '0;
    req_ch.valid_mask   = '0;
    req_ch.is_writeback = 1'b0;
    req_ch.was_hit      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Edge masks, the oldest way after reset, write-back hits and repeated same-set access.
    directed.push_back(victim_req(0, 16'hFFFF));
    directed.push_back(victim_req(SETS - 1, 16'h0000));
    directed.push_back(victim_req(5, 16'h7FFF));
    directed.push_back(victim_req(5, 16'hFFFE));
    directed.push_back(victim_req(5, 16'hFBFF));
    directed.push_back(update_req(0, WAYS - 1, 1'b0, 1'b0));
    directed.push_back(victim_req(0, 16'hFFFF));
    directed.push_back(update_req(0, 0, 1'b1, 1'b1));
    directed.push_back(victim_req(0, 16'hFFFF));
    directed.push_back(update_req(0, WAYS - 2, 1'b1, 1'b0));
    directed.push_back(update_req(0, WAYS - 3, 1'b0, 1'b1));
    directed.push_back(victim_req(0, 16'hFFFF));
    directed.push_back(update_req(0, WAYS - 1, 1'b0, 1'b0));
    directed.push_back(victim_req(0, 16'hFFFF));
    directed.push_back(update_req(SETS - 1, 0, 1'b0, 1'b0));
    directed.push_back(update_req(SETS - 1, 0, 1'b0, 1'b0));
    directed.push_back(victim_req(SETS - 1, 16'hFFFF));
    directed.push_back(update_req(SETS - 1, WAYS - 1, 1'b1, 1'b1));
    directed.push_back(victim_req(SETS - 1, 16'hFFFF));
    directed.push_back(victim_req(SETS - 1, 16'h8000));
    directed.push_back(update_req(512, WAYS - 1, 1'b0, 1'b0));
    directed.push_back(victim_req(512, 16'hFFFF));
    foreach (directed[i]) send_req(directed[i]);

    calm = 1'b0;
    foreach (hot_set[i]) hot_set[i] = $urandom_range(0, SETS - 1);
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued % 100 == 99) begin
        calm = ($urandom_range(0, 3) == 0);
        hot_set[$urandom_range(0, HOT_SETS - 1)] = $urandom_range(0, SETS - 1);
      end
      // Once, hold off until every victim in flight has come back.
      if (issued == RANDOM_ITEMS / 2) begin
        req_ch.valid = 1'b0;
        while (victims_pending != 0) @(negedge clk);
      end
      r = random_req();
      send_req(r);
      issued++;
    end
    req_ch.valid = 1'b0;

    while (victims_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- lru_replacement_set_core.f -----
rtl/core/lrs_pkg.sv
rtl/core/lrs_if.sv
rtl/core/lrs_rank_logic.sv
rtl/core/lru_replacement_set_core.sv
rtl/core/lrs_checker.sv
verif/lrs_checker.sv
verif/testbench.sv
